[src/hsss_pkg.sv]
package hsss_pkg;

	localparam int KNOT_W   = 32;
	localparam int INDEX_W  = 6;
	localparam int SEG_W    = 6;
	localparam int REGION_W = 2;
	localparam int CNT_W    = 7;

	localparam int MAX_KNOTS_DEFAULT      = 64;
	localparam int MAX_WALK_STEPS_DEFAULT = 8;

	localparam logic [CNT_W-1:0] KNOT_COUNT_RESET = CNT_W'(64);

	localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
	localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
	localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Microprogram steps; the step counter holds one of these.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CMP_FIRST,
		S_CMP_LAST,
		S_HINT,
		S_BIS_TEST,
		S_BIS_CMP,
		S_FWD_TEST,
		S_FWD_CMP,
		S_FWD_CHK,
		S_BWD_TEST,
		S_BWD_CMP,
		S_BWD_CHK,
		S_FIN
	} step_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_FIRST,
		RD_LAST,
		RD_MID,
		RD_NEXT,
		RD_CUR
	} rd_sel_t;

	typedef enum logic [3:0] {
		C_START,
		C_Q_LE_DATA,
		C_Q_GE_DATA,
		C_HINT_OK,
		C_SPAN,
		C_DATA_LE_Q,
		C_FWD,
		C_BWD,
		C_SPENT,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_BELOW,
		OP_ABOVE,
		OP_INSIDE,
		OP_LOAD_HINT,
		OP_BIS_INIT,
		OP_LO_MID,
		OP_HI_MID,
		OP_SEG_LO,
		OP_SEG_I,
		OP_CLR_STEPS,
		OP_STEP_FWD,
		OP_STEP_BWD,
		OP_EMIT
	} op_t;

	typedef struct packed {
		rd_sel_t rd;
		cond_t   cond;
		step_t   go_true;
		op_t     op_true;
		step_t   go_false;
		op_t     op_false;
	} ucode_t;

	// The control store: one word per step.
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			S_IDLE:      w = '{RD_FIRST, C_START,     S_CMP_FIRST, OP_START,
			                   S_IDLE,     OP_NONE};
			S_CMP_FIRST: w = '{RD_LAST,  C_Q_LE_DATA, S_FIN,       OP_BELOW,
			                   S_CMP_LAST, OP_NONE};
			S_CMP_LAST:  w = '{RD_NONE,  C_Q_GE_DATA, S_FIN,       OP_ABOVE,
			                   S_HINT,     OP_INSIDE};
			S_HINT:      w = '{RD_NONE,  C_HINT_OK,   S_FWD_TEST,  OP_LOAD_HINT,
			                   S_BIS_TEST, OP_BIS_INIT};
			S_BIS_TEST:  w = '{RD_MID,   C_SPAN,      S_BIS_CMP,   OP_NONE,
			                   S_FIN,      OP_SEG_LO};
			S_BIS_CMP:   w = '{RD_NONE,  C_DATA_LE_Q, S_BIS_TEST,  OP_LO_MID,
			                   S_BIS_TEST, OP_HI_MID};
			S_FWD_TEST:  w = '{RD_NEXT,  C_FWD,       S_FWD_CMP,   OP_NONE,
			                   S_BWD_TEST, OP_CLR_STEPS};
			S_FWD_CMP:   w = '{RD_NONE,  C_DATA_LE_Q, S_FWD_CHK,   OP_NONE,
			                   S_BWD_TEST, OP_CLR_STEPS};
			S_FWD_CHK:   w = '{RD_NONE,  C_SPENT,     S_BIS_TEST,  OP_BIS_INIT,
			                   S_FWD_TEST, OP_STEP_FWD};
			S_BWD_TEST:  w = '{RD_CUR,   C_BWD,       S_BWD_CMP,   OP_NONE,
			                   S_FIN,      OP_SEG_I};
			S_BWD_CMP:   w = '{RD_NONE,  C_DATA_LE_Q, S_FIN,       OP_SEG_I,
			                   S_BWD_CHK,  OP_NONE};
			S_BWD_CHK:   w = '{RD_NONE,  C_SPENT,     S_BIS_TEST,  OP_BIS_INIT,
			                   S_BWD_TEST, OP_STEP_BWD};
			S_FIN:       w = '{RD_NONE,  C_OUT_FREE,  S_IDLE,      OP_EMIT,
			                   S_FIN,      OP_NONE};
			default:     w = '{RD_NONE,  C_START,     S_IDLE,      OP_NONE,
			                   S_IDLE,     OP_NONE};
		endcase
		return w;
	endfunction

endpackage

[src/hsss_req_if.sv]
interface hsss_req_if;
	import hsss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [INDEX_W-1:0]        knot_index;
	logic signed [KNOT_W-1:0]  knot_value;
	logic signed [KNOT_W-1:0]  query_value;
	logic                      use_hint;

	modport source (
		output valid, kind, knot_index, knot_value, query_value, use_hint,
		input  ready
	);

	modport sink (
		input  valid, kind, knot_index, knot_value, query_value, use_hint,
		output ready
	);

endinterface

[src/hsss_rsp_if.sv]
interface hsss_rsp_if;
	import hsss_pkg::*;

	logic                valid;
	logic                ready;
	logic [SEG_W-1:0]    segment;
	logic [REGION_W-1:0] region;

	modport source (
		output valid, segment, region,
		input  ready
	);

	modport sink (
		input  valid, segment, region,
		output ready
	);

endinterface

[src/hinted_sorted_segment_search_unit.sv]
// Knot write: taken while idle, no result word. A query steps a microprogram that makes
// at most one knot RAM read per step (the read data is registered and used by the next
// step); it ends at or below the first knot, at or above the last, or inside through a
// binary search or a hinted walk (a walk that runs out falls back to the search); the
// result word becomes valid as the sequencer returns to idle, and a stalled result side
// holds the sequencer. Reset clears the sequencer and output valid flag, sets knot_count
// to 64 and the hint to 0; the knot RAM is left undefined.
module hinted_sorted_segment_search_unit #(
	parameter int MAX_KNOTS      = hsss_pkg::MAX_KNOTS_DEFAULT,
	parameter int MAX_WALK_STEPS = hsss_pkg::MAX_WALK_STEPS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hsss_pkg::CNT_W-1:0]  cfg_wdata,
	hsss_req_if.sink                    req,
	hsss_rsp_if.source                  rsp
);
	import hsss_pkg::*;

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int WW = $clog2(MAX_WALK_STEPS + 1);

	// Control state.
	step_t               step_q, step_d;
	logic [CNT_W-1:0]    knot_count_q;
	logic [SEG_W-1:0]    hint_q;
	logic                out_valid_q;

	// Datapath registers.
	logic signed [KNOT_W-1:0] query_q;
	logic                     hinted_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         lo_q, hi_q, idx_q, seg_q;
	logic [WW-1:0]            steps_q;
	logic [REGION_W-1:0]      region_q;
	logic [SEG_W-1:0]         out_seg_q;
	logic [REGION_W-1:0]      out_region_q;

	ucode_t           uc;
	logic             hit;
	op_t              op;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] n_start;
	logic [CNT_W-1:0] rd_idx;
	logic             rd_en;
	logic [KNOT_W-1:0] rd_data;
	logic signed [KNOT_W-1:0] knot;
	logic             accept;
	logic             knot_we;

	assign accept  = req.valid && req.ready;
	assign knot_we = accept && (req.kind == KIND_WRITE) && (int'(req.knot_index) < MAX_KNOTS);
	assign knot    = $signed(rd_data);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];

	always_comb begin
		if (knot_count_q < CNT_W'(2)) begin
			n_start = CNT_W'(2);
		end else if (int'(knot_count_q) > MAX_KNOTS) begin
			n_start = CNT_W'(MAX_KNOTS);
		end else begin
			n_start = knot_count_q;
		end
	end

	hsss_ram #(
		.WIDTH (KNOT_W),
		.DEPTH (MAX_KNOTS)
	) u_knots (
		.clk   (clk),
		.we    (knot_we),
		.waddr (AW'(req.knot_index)),
		.wdata (req.knot_value),
		.re    (rd_en),
		.raddr (AW'(rd_idx)),
		.rdata (rd_data)
	);

	// Condition evaluation and next step.
	always_comb begin
		uc = ucode_rom(step_q);
		unique case (uc.cond)
			C_START:     hit = req.valid && (req.kind == KIND_QUERY);
			C_Q_LE_DATA: hit = query_q <= knot;
			C_Q_GE_DATA: hit = query_q >= knot;
			C_HINT_OK:   hit = hinted_q && ((CNT_W'(hint_q) + CNT_W'(2)) <= n_q);
			C_SPAN:      hit = (lo_q + CNT_W'(1)) < hi_q;
			C_DATA_LE_Q: hit = knot <= query_q;
			C_FWD:       hit = (idx_q + CNT_W'(2)) < n_q;
			C_BWD:       hit = idx_q != '0;
			C_SPENT:     hit = steps_q == WW'(MAX_WALK_STEPS);
			C_OUT_FREE:  hit = !out_valid_q || rsp.ready;
			default:     hit = 1'b0;
		endcase
		step_d = hit ? uc.go_true : uc.go_false;
		op     = hit ? uc.op_true : uc.op_false;
	end

	// Outputs of the control word.
	always_comb begin
		req.ready = step_q == S_IDLE;
		rd_en     = uc.rd != RD_NONE;
		unique case (uc.rd)
			RD_FIRST: rd_idx = '0;
			RD_LAST:  rd_idx = n_q - CNT_W'(1);
			RD_MID:   rd_idx = mid;
			RD_NEXT:  rd_idx = idx_q + CNT_W'(1);
			RD_CUR:   rd_idx = idx_q;
			default:  rd_idx = '0;
		endcase
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.segment = out_seg_q;
	assign rsp.region  = out_region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= S_IDLE;
			knot_count_q <= KNOT_COUNT_RESET;
			hint_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_we) begin
				knot_count_q <= cfg_wdata;
			end
			if (op == OP_EMIT) begin
				out_valid_q <= 1'b1;
				if (hinted_q) begin
					hint_q <= seg_q[SEG_W-1:0];
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_START: begin
				query_q  <= req.query_value;
				hinted_q <= req.use_hint;
				n_q      <= n_start;
			end
			OP_BELOW: begin
				seg_q    <= '0;
				region_q <= REGION_BELOW;
			end
			OP_ABOVE: begin
				seg_q    <= n_q - CNT_W'(2);
				region_q <= REGION_ABOVE;
			end
			OP_INSIDE:    region_q <= REGION_INSIDE;
			OP_LOAD_HINT: begin
				idx_q   <= CNT_W'(hint_q);
				steps_q <= '0;
			end
			OP_BIS_INIT: begin
				lo_q <= '0;
				hi_q <= n_q - CNT_W'(1);
			end
			OP_LO_MID:    lo_q    <= mid;
			OP_HI_MID:    hi_q    <= mid;
			OP_SEG_LO:    seg_q   <= lo_q;
			OP_SEG_I:     seg_q   <= idx_q;
			OP_CLR_STEPS: steps_q <= '0;
			OP_STEP_FWD: begin
				idx_q   <= idx_q + CNT_W'(1);
				steps_q <= steps_q + WW'(1);
			end
			OP_STEP_BWD: begin
				idx_q   <= idx_q - CNT_W'(1);
				steps_q <= steps_q + WW'(1);
			end
			OP_EMIT: begin
				out_seg_q    <= seg_q[SEG_W-1:0];
				out_region_q <= region_q;
			end
			default: ;
		endcase
	end

endmodule

[src/hsss_ram.sv]
module hsss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[bench/hinted_sorted_segment_search_unit_tb.sv]
module hinted_sorted_segment_search_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsss_pkg::*;

	localparam int MAX_KNOTS      = MAX_KNOTS_DEFAULT;
	localparam int WALK_LIMIT     = MAX_WALK_STEPS_DEFAULT;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int CFG_SETTLE     = 16;
	localparam int TAIL_CYCLES    = 80;
	localparam int PHASE_ITEMS    = 40;
	localparam int REPORT_LIMIT   = 10;
	localparam longint KNOT_MIN   = -(longint'(1) << 31);
	localparam longint KNOT_MAX   = (longint'(1) << 31) - 1;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] knot_index;
		logic [KNOT_W-1:0]  knot_value;
		logic [KNOT_W-1:0]  query_value;
		logic               use_hint;
	} req_word_t;

	typedef struct packed {
		logic [SEG_W-1:0]    segment;
		logic [REGION_W-1:0] region;
	} answer_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		logic        hinted;
		logic        typed;
		answer_t     want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 20;

	// Two-knot table first (count saturated up from zero), then four knots.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_CFG,   32'd0, 32'd0,          1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd0, 32'h8000_0000,  1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd1, 32'h7FFF_FFFF,  1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'h8000_0000,  1'b1, 1'b1, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'h7FFF_FFFF,  1'b1, 1'b1, '{6'd0, REGION_ABOVE}},
		'{ROW_QUERY, 32'd0, 32'd0,          1'b1, 1'b1, '{6'd0, REGION_INSIDE}},
		'{ROW_WRITE, 32'd0, 32'd10,         1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd1, 32'hFFFF_FFF6,  1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'd0,          1'b0, 1'b1, '{6'd0, REGION_BELOW}},
		'{ROW_CFG,   32'd4, 32'd0,          1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd0, 32'hFFFF_FED4,  1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd1, 32'hFFFF_FF9C,  1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd2, 32'd100,        1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_WRITE, 32'd3, 32'd300,        1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'd200,        1'b1, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'hFFFF_FF38,  1'b1, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'd0,          1'b0, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'd300,        1'b1, 1'b1, '{6'd2, REGION_ABOVE}},
		'{ROW_QUERY, 32'd0, 32'hFFFF_FF9C,  1'b1, 1'b0, '{6'd0, REGION_BELOW}},
		'{ROW_QUERY, 32'd0, 32'hFFFF_FED4,  1'b0, 1'b1, '{6'd0, REGION_BELOW}}
	};

	int phase_counts [] = '{127, 3, 64, 1, 40, 2, 100, 9, 64, 0, 33};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	hsss_req_if req_ch ();
	hsss_rsp_if rsp_ch ();

	hinted_sorted_segment_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predictor state, kept in step with the words the block has accepted.
	logic signed [KNOT_W-1:0] knot_copy [MAX_KNOTS];
	int                       hint_copy;
	logic [CNT_W-1:0]         count_copy;
	answer_t                  pending_answers [$];

	int failures;
	int words_checked;
	int knots_written;
	int queries_sent;
	int hinted_queries;
	int burst_left;
	bit steady_sender;
	int sink_mode;
	int hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int knots_in_use();
		if (count_copy < 2) return 2;
		if (count_copy > MAX_KNOTS) return MAX_KNOTS;
		return int'(count_copy);
	endfunction

	function automatic int bisect_segment(input int n, input logic signed [KNOT_W-1:0] q);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (knot_copy[mid] <= q) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	// Forward walk, then backward walk; either running out of steps means bisection.
	function automatic int walk_from_hint(input int n, input logic signed [KNOT_W-1:0] q,
	                                      input int start);
		int i;
		int steps;
		i = start;
		steps = 0;
		if (i > n - 2) return bisect_segment(n, q);
		while (i < n - 2 && knot_copy[i + 1] <= q) begin
			if (steps >= WALK_LIMIT) return bisect_segment(n, q);
			steps++;
			i++;
		end
		steps = 0;
		while (i > 0 && knot_copy[i] > q) begin
			if (steps >= WALK_LIMIT) return bisect_segment(n, q);
			steps++;
			i--;
		end
		return i;
	endfunction

	function automatic answer_t locate_segment(input logic [KNOT_W-1:0] q_bits,
	                                           input logic hinted);
		answer_t ans;
		logic signed [KNOT_W-1:0] q;
		int n;
		int seg;
		q = $signed(q_bits);
		n = knots_in_use();
		// The lower end is tested first, so it wins when both ends apply.
		if (q <= knot_copy[0]) begin
			seg = 0;
			ans.region = REGION_BELOW;
		end else if (q >= knot_copy[n - 1]) begin
			seg = n - 2;
			ans.region = REGION_ABOVE;
		end else begin
			ans.region = REGION_INSIDE;
			seg = hinted ? walk_from_hint(n, q, hint_copy) : bisect_segment(n, q);
		end
		if (hinted) hint_copy = seg % 64;
		ans.segment = SEG_W'(seg);
		return ans;
	endfunction

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
	endfunction

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_for_answers();
		while (pending_answers.size() != 0) @(negedge clk);
	endtask

	// Offers one word and returns at the edge that accepts it.
	task automatic send_word(input req_word_t w, input bit typed, input answer_t want);
		answer_t ans;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!steady_sender) pause_sender($urandom_range(1, 10));
		end
		burst_left--;
		@(negedge clk);
		req_ch.kind        <= w.kind;
		req_ch.knot_index  <= w.knot_index;
		req_ch.knot_value  <= w.knot_value;
		req_ch.query_value <= w.query_value;
		req_ch.use_hint    <= w.use_hint;
		req_ch.valid       <= 1'b1;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		if (w.kind == KIND_WRITE) begin
			knot_copy[w.knot_index] = $signed(w.knot_value);
			knots_written++;
		end else begin
			ans = locate_segment(w.query_value, w.use_hint);
			if (typed) ans = want;
			pending_answers.push_back(ans);
			queries_sent++;
			if (w.use_hint) hinted_queries++;
		end
	endtask

	task automatic set_knot_count(input logic [CNT_W-1:0] value);
		pause_sender(1);
		wait_for_answers();
		// A trailing knot write may still be in the block.
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_copy = value;
	endtask

	task automatic load_ascending_table(input int n, input bit full_range);
		int vals [$];
		int mode;
		int level;
		int k;
		mode = full_range ? 0 : $urandom_range(0, 2);
		level = int'($urandom_range(0, 2097152)) - 1048576;
		for (k = 0; k < n; k++) begin
			case (mode)
				0: vals.push_back(int'($urandom));
				1: begin
					level += $urandom_range(0, 300);
					vals.push_back(level);
				end
				default: begin
					level += $urandom_range(0, 2);
					vals.push_back(level);
				end
			endcase
		end
		vals.sort();
		for (k = 0; k < n; k++)
			send_word('{KIND_WRITE, INDEX_W'(k), vals[k], $urandom, 1'($urandom)}, 1'b0, '0);
	endtask

	function automatic logic [KNOT_W-1:0] point_in_segment(input int j);
		longint lo;
		longint hi;
		lo = knot_copy[j];
		hi = knot_copy[j + 1];
		if (hi <= lo) return lo[KNOT_W-1:0];
		return KNOT_W'(lo + longint'($urandom_range(0, 32'(hi - lo - 1))));
	endfunction

	function automatic req_word_t random_item(input int n);
		req_word_t w;
		int pick;
		int j;
		longint v;
		w.kind        = KIND_QUERY;
		w.knot_index  = $urandom;
		w.knot_value  = $urandom;
		w.query_value = '0;
		w.use_hint    = ($urandom_range(0, 99) < 85);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// Close to the stored hint, so that short walks dominate.
			j = (hint_copy > n - 2) ? int'($urandom_range(0, n - 2)) : hint_copy;
			j = j + int'($urandom_range(0, 6)) - 3;
			if (j < 0) j = 0;
			if (j > n - 2) j = n - 2;
			w.query_value = point_in_segment(j);
		end else if (pick < 75) begin
			w.query_value = point_in_segment($urandom_range(0, n - 2));
		end else if (pick < 82) begin
			w.query_value = knot_copy[$urandom_range(0, n - 1)];
		end else if (pick < 88) begin
			v = longint'(knot_copy[0]) - longint'($urandom_range(0, 1000));
			if (v < KNOT_MIN) v = KNOT_MIN;
			w.query_value = v[KNOT_W-1:0];
		end else if (pick < 94) begin
			v = longint'(knot_copy[n - 1]) + longint'($urandom_range(0, 1000));
			if (v > KNOT_MAX) v = KNOT_MAX;
			w.query_value = v[KNOT_W-1:0];
		end else if (pick < 97) begin
			w.query_value = $urandom;
		end else begin
			// A stray knot write, which may leave the table out of order.
			w.kind        = KIND_WRITE;
			w.knot_index  = $urandom_range(0, MAX_KNOTS - 1);
			w.query_value = $urandom;
		end
		return w;
	endfunction

	initial begin : result_sink
		int hold_left;
		int tick;
		hold_left = 0;
		tick = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (sink_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= (tick % 7 < 4);
					default: rsp_ch.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_result
		answer_t want;
		answer_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.segment = rsp_ch.segment;
			got.region  = rsp_ch.region;
			words_checked++;
			if (pending_answers.size() == 0) begin
				note_failure($sformatf("result word with none due: segment %0d region %0d",
				                       got.segment, got.region));
			end else begin
				want = pending_answers.pop_front();
				if (got.segment !== want.segment)
					note_failure($sformatf("segment expected %0d, got %0d",
					                       want.segment, got.segment));
				if (got.region !== want.region)
					note_failure($sformatf("region expected %0d, got %0d",
					                       want.region, got.region));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
		         cycles, pending_answers.size());
		$display("** hinted_sorted_segment_search_unit: FAILED **");
		$finish;
	end

	initial begin : stimulus
		req_word_t w;
		int r;
		int p;
		int k;
		int n;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.kind        = KIND_WRITE;
		req_ch.knot_index  = '0;
		req_ch.knot_value  = '0;
		req_ch.query_value = '0;
		req_ch.use_hint    = 1'b0;
		for (k = 0; k < MAX_KNOTS; k++) knot_copy[k] = '0;
		hint_copy      = 0;
		count_copy     = KNOT_COUNT_RESET;
		failures       = 0;
		words_checked  = 0;
		knots_written  = 0;
		queries_sent   = 0;
		hinted_queries = 0;
		burst_left     = 0;
		steady_sender  = 1'b0;
		sink_mode      = 1;
		hold_request   = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			case (directed_rows[r].op)
				ROW_CFG: set_knot_count(directed_rows[r].a[CNT_W-1:0]);
				ROW_WRITE: send_word('{KIND_WRITE, directed_rows[r].a[INDEX_W-1:0],
				                       directed_rows[r].b, 32'd0, 1'b0}, 1'b0, '0);
				default: send_word('{KIND_QUERY, INDEX_W'(0), 32'd0, directed_rows[r].b,
				                     directed_rows[r].hinted},
				                   directed_rows[r].typed, directed_rows[r].want);
			endcase
		end

		// The first setting uses the whole table, so it is loaded in full there.
		for (p = 0; p < phase_counts.size(); p++) begin
			set_knot_count(CNT_W'(phase_counts[p]));
			n = knots_in_use();
			steady_sender = (p % 4 == 3);
			sink_mode = (p + 1) % 4;
			if (p == 0 || $urandom_range(0, 2) == 0) load_ascending_table(n, p == 0);
			// Hold the result side off while words keep coming, so the block backs up.
			if (p == 2) hold_request = 400;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 5 && k == PHASE_ITEMS / 2) begin
					pause_sender(1);
					wait_for_answers();
				end
				w = random_item(n);
				send_word(w, 1'b0, '0);
			end
		end

		pause_sender(1);
		wait_for_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_answers.size()));

		$display("Covered %0d knot writes and %0d queries (%0d hinted) over %0d knot counts,",
		         knots_written, queries_sent, hinted_queries, phase_counts.size() + 2);
		$display("including unordered tables and stale hints; %0d result words checked.",
		         words_checked);
		if (failures == 0) begin
			$display("** hinted_sorted_segment_search_unit: PASSED **");
		end else begin
			$display("%0d mismatches in total.", failures);
			$display("** hinted_sorted_segment_search_unit: FAILED **");
		end
		$finish;
	end

endmodule
